[hw/rtl/sixrm_pkg.sv]
// ============================================================================
// sixrm_pkg
// shared types and constants for the six register machine execute block
// ============================================================================
package sixrm_pkg;

    localparam int NUM_REGISTERS_DEF = 6;
    localparam int REG_W             = 64;
    localparam int OPND_W            = 32;
    localparam int DEST_W            = 3;
    localparam int PTR_REG_W         = 3;
    localparam int PROG_LEN_W        = 13;

    typedef enum logic [3:0] {
        OP_ADDR = 4'd0,
        OP_ADDI = 4'd1,
        OP_MULR = 4'd2,
        OP_MULI = 4'd3,
        OP_BANR = 4'd4,
        OP_BANI = 4'd5,
        OP_BORR = 4'd6,
        OP_BORI = 4'd7,
        OP_SETR = 4'd8,
        OP_SETI = 4'd9,
        OP_GTIR = 4'd10,
        OP_GTRI = 4'd11,
        OP_GTRR = 4'd12,
        OP_EQIR = 4'd13,
        OP_EQRI = 4'd14,
        OP_EQRR = 4'd15
    } t_opcode;

    typedef logic [REG_W-1:0] t_word;

endpackage

[hw/rtl/sixrm_alu.sv]
// ============================================================================
// sixrm_alu
// single pass operation unit: add, and, or, set, signed compares, and the
// final sum, formed in the top and only selected here, of a registered multiply
// ============================================================================
module sixrm_alu (
    input  sixrm_pkg::t_opcode i_op,
    input  sixrm_pkg::t_word   i_va,
    input  sixrm_pkg::t_word   i_vb,
    input  sixrm_pkg::t_word   i_mul_prod,
    output sixrm_pkg::t_word   o_res
);
    import sixrm_pkg::*;

    logic gt_flag;
    logic eq_flag;

    assign gt_flag = $signed(i_va) > $signed(i_vb);
    assign eq_flag = (i_va == i_vb);

    always_comb begin
        case (i_op)
            OP_ADDR, OP_ADDI: o_res = i_va + i_vb;
            OP_MULR, OP_MULI: o_res = i_mul_prod;
            OP_BANR, OP_BANI: o_res = i_va & i_vb;
            OP_BORR, OP_BORI: o_res = i_va | i_vb;
            OP_SETR, OP_SETI: o_res = i_va;
            OP_GTIR, OP_GTRI, OP_GTRR: o_res = {{(REG_W-1){1'b0}}, gt_flag};
            OP_EQIR, OP_EQRI, OP_EQRR: o_res = {{(REG_W-1){1'b0}}, eq_flag};
            default: o_res = '0;
        endcase
    end

endmodule

[hw/rtl/six_register_machine_execute_top.sv]
// ============================================================================
// six_register_machine_execute_top
// executes one instruction per transaction on a small register machine with
// a bound instruction pointer, register file held in flip-flops
// ============================================================================
// path: input register, then result register
// throughput: 1 instruction per cycle unless the output stalls; mulr and
//   muli wait on the 64-bit multiply's registered 32x32 partial products
// reset: synchronous active low; registers, pointer and config clear to zero
// ============================================================================
module six_register_machine_execute_top #(
    parameter int NUM_REGISTERS = sixrm_pkg::NUM_REGISTERS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [3:0]                          i_opcode,
    input  logic signed [sixrm_pkg::OPND_W-1:0] i_operand_a,
    input  logic signed [sixrm_pkg::OPND_W-1:0] i_operand_b,
    input  logic [sixrm_pkg::DEST_W-1:0]        i_dest_index,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [sixrm_pkg::REG_W-1:0]  o_next_pointer,
    output logic signed [sixrm_pkg::REG_W-1:0]  o_written_value,
    output logic                                o_bad_register,
    output logic                                o_halted,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import sixrm_pkg::*;

    localparam int   IDX_W        = (NUM_REGISTERS > 1) ? $clog2(NUM_REGISTERS) : 1;
    localparam logic CFG_PTR_REG  = 1'b0;
    localparam logic CFG_PROG_LEN = 1'b1;

    // configuration
    logic [PTR_REG_W-1:0]  r_ptr_reg;
    logic [PROG_LEN_W-1:0] r_prog_len;

    // machine state
    t_word r_rf [NUM_REGISTERS];
    t_word r_ip;

    // input register
    logic                     r_s1_vld;
    t_opcode                  r_s1_op;
    logic signed [OPND_W-1:0] r_s1_a;
    logic signed [OPND_W-1:0] r_s1_b;
    logic [DEST_W-1:0]        r_s1_c;

    // multiply partial products
    t_word             r_pp_lo;
    logic [OPND_W-1:0] r_pp_ha;
    logic [OPND_W-1:0] r_pp_hb;
    logic              r_pp_rdy;

    // result register
    logic  r_out_vld;
    t_word r_out_np;
    t_word r_out_wv;
    logic  r_out_bad;
    logic  r_out_halt;

    logic              cfg_wr;
    logic              in_acc;
    logic              s1_adv;
    logic              need_pp;
    logic              ip_run;
    logic              halt_now;
    logic              bound;
    logic [IDX_W-1:0]  ptr_idx;
    logic [IDX_W-1:0]  a_idx;
    logic [IDX_W-1:0]  b_idx;
    logic [IDX_W-1:0]  c_idx;
    logic              a_reg;
    logic              b_reg;
    logic              a_ok;
    logic              b_ok;
    logic              c_ok;
    logic              bad;
    logic              is_mul;
    t_word             rf_eff [NUM_REGISTERS];
    t_word             va;
    t_word             vb;
    t_word             pp_lo;
    logic [OPND_W-1:0] pp_ha;
    logic [OPND_W-1:0] pp_hb;
    t_word             mul_prod;
    t_word             res;
    t_word             res_w;
    t_word             ptr_src;
    t_word             n_ip;
    logic              next_run;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[2])
            CFG_PTR_REG:  prdata = {{(32-PTR_REG_W){1'b0}}, r_ptr_reg};
            CFG_PROG_LEN: prdata = {{(32-PROG_LEN_W){1'b0}}, r_prog_len};
            default:      prdata = '0;
        endcase
    end

    // handshake
    assign is_mul   = (r_s1_op == OP_MULR) || (r_s1_op == OP_MULI);
    assign need_pp  = r_s1_vld && is_mul && !halt_now && !bad && !r_pp_rdy;
    assign s1_adv   = r_s1_vld && !need_pp && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_s1_vld && !s1_adv;
    assign in_acc   = i_in_valid && !o_in_stall;

    // pointer and bound register
    assign ip_run   = r_ip < {{(REG_W-PROG_LEN_W){1'b0}}, r_prog_len};
    assign halt_now = !ip_run;
    assign bound    = int'(r_ptr_reg) < NUM_REGISTERS;
    assign ptr_idx  = IDX_W'(r_ptr_reg);

    always_comb begin
        for (int i = 0; i < NUM_REGISTERS; i++) begin
            rf_eff[i] = (bound && ptr_idx == IDX_W'(i)) ? r_ip : r_rf[i];
        end
    end

    // operand kinds
    always_comb begin
        a_reg = 1'b1;
        b_reg = 1'b1;
        case (r_s1_op)
            OP_ADDI, OP_MULI, OP_BANI, OP_BORI, OP_SETR: b_reg = 1'b0;
            OP_SETI: begin
                a_reg = 1'b0;
                b_reg = 1'b0;
            end
            OP_GTIR, OP_EQIR: a_reg = 1'b0;
            OP_GTRI, OP_EQRI: b_reg = 1'b0;
            default: begin
                a_reg = 1'b1;
                b_reg = 1'b1;
            end
        endcase
    end

    assign a_ok  = $unsigned(r_s1_a) < 32'(NUM_REGISTERS);
    assign b_ok  = $unsigned(r_s1_b) < 32'(NUM_REGISTERS);
    assign c_ok  = int'(r_s1_c) < NUM_REGISTERS;
    assign a_idx = r_s1_a[IDX_W-1:0];
    assign b_idx = r_s1_b[IDX_W-1:0];
    assign c_idx = IDX_W'(r_s1_c);
    assign bad   = (a_reg && !a_ok) || (b_reg && !b_ok) || !c_ok;

    assign va = !a_reg ? {{(REG_W-OPND_W){r_s1_a[OPND_W-1]}}, r_s1_a} :
                a_ok   ? rf_eff[a_idx] : '0;
    assign vb = !b_reg ? {{(REG_W-OPND_W){r_s1_b[OPND_W-1]}}, r_s1_b} :
                b_ok   ? rf_eff[b_idx] : '0;

    // 64-bit product, low half only, from 32x32 partial products
    assign pp_lo    = {32'd0, va[31:0]} * {32'd0, vb[31:0]};
    assign pp_ha    = va[31:0] * vb[63:32];
    assign pp_hb    = va[63:32] * vb[31:0];
    assign mul_prod = r_pp_lo + {r_pp_ha + r_pp_hb, 32'd0};

    sixrm_alu u_alu (
        .i_op       (r_s1_op),
        .i_va       (va),
        .i_vb       (vb),
        .i_mul_prod (mul_prod),
        .o_res      (res)
    );

    assign res_w    = bad ? '0 : res;
    assign ptr_src  = (bound && !bad && c_idx == ptr_idx) ? res : r_ip;
    assign n_ip     = ptr_src + 64'd1;
    assign next_run = n_ip < {{(REG_W-PROG_LEN_W){1'b0}}, r_prog_len};

    // config and machine state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr_reg  <= '0;
            r_prog_len <= '0;
            r_ip       <= '0;
            for (int i = 0; i < NUM_REGISTERS; i++) begin
                r_rf[i] <= '0;
            end
        end else begin
            if (cfg_wr) begin
                case (paddr[2])
                    CFG_PTR_REG:  r_ptr_reg  <= pwdata[PTR_REG_W-1:0];
                    CFG_PROG_LEN: r_prog_len <= pwdata[PROG_LEN_W-1:0];
                    default: begin
                        r_ptr_reg <= r_ptr_reg;
                    end
                endcase
            end
            if (s1_adv && !halt_now) begin
                // destination write takes priority over the pointer copy
                for (int i = 0; i < NUM_REGISTERS; i++) begin
                    if (!bad && c_idx == IDX_W'(i)) begin
                        r_rf[i] <= res;
                    end else if (bound && ptr_idx == IDX_W'(i)) begin
                        r_rf[i] <= r_ip;
                    end
                end
                r_ip <= n_ip;
            end
        end
    end

    // input register and partial products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_pp_rdy <= 1'b0;
        end else begin
            r_s1_vld <= in_acc || (r_s1_vld && !s1_adv);
            r_pp_rdy <= r_s1_vld && !s1_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op <= t_opcode'(i_opcode);
            r_s1_a  <= i_operand_a;
            r_s1_b  <= i_operand_b;
            r_s1_c  <= i_dest_index;
        end
        r_pp_lo <= pp_lo;
        r_pp_ha <= pp_ha;
        r_pp_hb <= pp_hb;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= s1_adv || (r_out_vld && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            if (halt_now) begin
                r_out_np   <= r_ip;
                r_out_wv   <= '0;
                r_out_bad  <= 1'b0;
                r_out_halt <= 1'b1;
            end else begin
                r_out_np   <= n_ip;
                r_out_wv   <= res_w;
                r_out_bad  <= bad;
                r_out_halt <= !next_run;
            end
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_next_pointer  = r_out_np;
    assign o_written_value = r_out_wv;
    assign o_bad_register  = r_out_bad;
    assign o_halted        = r_out_halt;

endmodule

[bench/six_register_machine_execute_checker.sv]
// ============================================================================
// six_register_machine_execute_checker
// watches the instruction, result and register port of the machine, keeps
// its own copy of the register file, pointer and config, predicts each
// result and compares it field by field with what the block returns
// ============================================================================
module six_register_machine_execute_checker #(
    parameter int         NUM_REGISTERS    = 6,
    parameter logic [2:0] ADDR_POINTER_REG = 3'd0,
    parameter logic [2:0] ADDR_PROGRAM_LEN = 3'd4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [3:0]  i_opcode,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    input  logic [2:0]  i_dest_index,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [63:0] i_next_pointer,
    input  logic [63:0] i_written_value,
    input  logic        i_bad_register,
    input  logic        i_halted,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count,
    output int          o_halted_count,
    output int          o_bad_count,
    output int          o_config_writes
);
    timeunit 1ns;
    timeprecision 1ps;
    import sixrm_pkg::*;

    typedef struct packed {
        t_word next_pointer;
        t_word written_value;
        logic  bad_register;
        logic  halted;
    } t_step_result;

    t_word        machine_regs [NUM_REGISTERS];
    t_word        machine_ip;
    logic [2:0]   bound_sel;
    logic [12:0]  prog_len;
    t_step_result expected_results [$];
    t_step_result want;
    int           fail_count;
    int           result_count;
    int           halted_count;
    int           bad_count;
    int           config_writes;

    task automatic report_mismatch(input string what, input t_word got, input t_word exp_val);
        $display("mismatch on %s at result %0d: got %h, expected %h",
                 what, result_count, got, exp_val);
        fail_count++;
    endtask

    function automatic logic in_program(input t_word v);
        return !v[63] && (v < 64'(prog_len));
    endfunction

    function automatic logic is_register(input logic [31:0] idx);
        return !idx[31] && (idx < NUM_REGISTERS);
    endfunction

    function automatic t_step_result execute_step(input logic [3:0] opcode,
                                                  input logic [31:0] opnd_a,
                                                  input logic [31:0] opnd_b,
                                                  input logic [2:0] dest);
        t_step_result r;
        t_word        va;
        t_word        vb;
        t_word        value;
        logic         a_reg;
        logic         b_reg;
        logic         bad;
        logic         bound;
        va    = {{32{opnd_a[31]}}, opnd_a};
        vb    = {{32{opnd_b[31]}}, opnd_b};
        value = '0;
        bad   = 1'b0;
        bound = bound_sel < NUM_REGISTERS;
        if (!in_program(machine_ip)) begin
            r.next_pointer  = machine_ip;
            r.written_value = '0;
            r.bad_register  = 1'b0;
            r.halted        = 1'b1;
            return r;
        end
        if (bound) begin
            machine_regs[bound_sel] = machine_ip;
        end
        case (t_opcode'(opcode))
            OP_SETI: begin
                a_reg = 1'b0;
                b_reg = 1'b0;
            end
            OP_SETR, OP_GTRI, OP_EQRI: begin
                a_reg = 1'b1;
                b_reg = 1'b0;
            end
            OP_GTIR, OP_EQIR: begin
                a_reg = 1'b0;
                b_reg = 1'b1;
            end
            OP_GTRR, OP_EQRR: begin
                a_reg = 1'b1;
                b_reg = 1'b1;
            end
            default: begin
                a_reg = 1'b1;
                b_reg = !opcode[0];
            end
        endcase
        if (a_reg) begin
            if (is_register(opnd_a)) va = machine_regs[int'(opnd_a)];
            else bad = 1'b1;
        end
        if (b_reg) begin
            if (is_register(opnd_b)) vb = machine_regs[int'(opnd_b)];
            else bad = 1'b1;
        end
        if (dest >= NUM_REGISTERS) bad = 1'b1;
        if (!bad) begin
            case (t_opcode'(opcode))
                OP_ADDR, OP_ADDI: value = va + vb;
                OP_MULR, OP_MULI: value = va * vb;
                OP_BANR, OP_BANI: value = va & vb;
                OP_BORR, OP_BORI: value = va | vb;
                OP_SETR, OP_SETI: value = va;
                OP_GTIR, OP_GTRI, OP_GTRR: value = ($signed(va) > $signed(vb)) ? 64'd1 : 64'd0;
                default: value = (va == vb) ? 64'd1 : 64'd0;
            endcase
            machine_regs[dest] = value;
        end
        machine_ip      = (bound ? machine_regs[bound_sel] : machine_ip) + 64'd1;
        r.next_pointer  = machine_ip;
        r.written_value = value;
        r.bad_register  = bad;
        r.halted        = !in_program(machine_ip);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (machine_regs[i]) machine_regs[i] = '0;
            machine_ip = '0;
            bound_sel  = '0;
            prog_len   = '0;
            expected_results.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    config_writes++;
                    case (paddr)
                        ADDR_POINTER_REG: bound_sel = pwdata[2:0];
                        ADDR_PROGRAM_LEN: prog_len  = pwdata[12:0];
                        default: ;
                    endcase
                end else begin
                    case (paddr)
                        ADDR_POINTER_REG: begin
                            if (prdata[2:0] !== bound_sel)
                                report_mismatch("pointer_register readback",
                                                64'(prdata), 64'(bound_sel));
                        end
                        ADDR_PROGRAM_LEN: begin
                            if (prdata[12:0] !== prog_len)
                                report_mismatch("program_length readback",
                                                64'(prdata), 64'(prog_len));
                        end
                        default: ;
                    endcase
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(execute_step(i_opcode, i_operand_a,
                                                        i_operand_b, i_dest_index));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("transaction with nothing outstanding", i_next_pointer, '0);
                end else begin
                    want = expected_results.pop_front();
                    result_count++;
                    if (want.halted) halted_count++;
                    if (want.bad_register) bad_count++;
                    if (i_next_pointer !== want.next_pointer)
                        report_mismatch("next_pointer", i_next_pointer, want.next_pointer);
                    if (i_written_value !== want.written_value)
                        report_mismatch("written_value", i_written_value, want.written_value);
                    if (i_bad_register !== want.bad_register)
                        report_mismatch("bad_register", 64'(i_bad_register),
                                        64'(want.bad_register));
                    if (i_halted !== want.halted)
                        report_mismatch("halted", 64'(i_halted), 64'(want.halted));
                end
            end
        end
        o_fail_count    <= fail_count;
        o_pending       <= expected_results.size();
        o_result_count  <= result_count;
        o_halted_count  <= halted_count;
        o_bad_count     <= bad_count;
        o_config_writes <= config_writes;
    end

endmodule

[bench/six_register_machine_execute_top_tb.sv]
// ============================================================================
// six_register_machine_execute_top_tb
// drives instructions and register writes into the machine: a directed set
// over every operation and corner, then random programs under a series of
// pointer bindings and program lengths, with bursty input and random stalls
// ============================================================================
module six_register_machine_execute_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sixrm_pkg::*;

    localparam int         NUM_REGS         = NUM_REGISTERS_DEF;
    localparam logic [2:0] ADDR_POINTER_REG = 3'd0;
    localparam logic [2:0] ADDR_PROGRAM_LEN = 3'd4;
    localparam int         IDLE_LIMIT       = 2000;
    localparam int         PHASES           = 8;
    localparam int         PHASE_ITEMS      = 150;

    logic                       i_clk           = 1'b0;
    logic                       i_rst_n         = 1'b0;
    logic                       i_in_valid      = 1'b0;
    logic                       o_in_stall;
    logic [3:0]                 i_opcode        = '0;
    logic signed [OPND_W-1:0]   i_operand_a     = '0;
    logic signed [OPND_W-1:0]   i_operand_b     = '0;
    logic [DEST_W-1:0]          i_dest_index    = '0;
    logic                       o_out_valid;
    logic                       i_out_stall     = 1'b0;
    logic signed [REG_W-1:0]    o_next_pointer;
    logic signed [REG_W-1:0]    o_written_value;
    logic                       o_bad_register;
    logic                       o_halted;
    logic                       psel            = 1'b0;
    logic                       penable         = 1'b0;
    logic                       pwrite          = 1'b0;
    logic [2:0]                 paddr           = '0;
    logic [31:0]                pwdata          = '0;
    logic [31:0]                prdata;
    logic                       pready;

    int fail_count;
    int pending;
    int result_count;
    int halted_count;
    int bad_count;
    int config_writes;

    int item_count  = 0;
    int burst_left  = 0;
    int bound_reg   = 0;
    int jump_span   = 1;
    int idle_cycles = 0;
    int stall_mode  = 0;
    int stall_left  = 0;
    int stall_tick  = 0;

    int phase_ptr [PHASES] = '{5, 6, 0, 7, 3, 2, 1, 4};
    int phase_len [PHASES] = '{4096, 8191, 4096, 4096, 64, 1, 4096, 8191};

    six_register_machine_execute_top #(
        .NUM_REGISTERS(NUM_REGS)
    ) DUT (.*);

    six_register_machine_execute_checker #(
        .NUM_REGISTERS   (NUM_REGS),
        .ADDR_POINTER_REG(ADDR_POINTER_REG),
        .ADDR_PROGRAM_LEN(ADDR_PROGRAM_LEN)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .i_dest_index   (i_dest_index),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_next_pointer (o_next_pointer),
        .i_written_value(o_written_value),
        .i_bad_register (o_bad_register),
        .i_halted       (o_halted),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_halted_count (halted_count),
        .o_bad_count    (bad_count),
        .o_config_writes(config_writes)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // receiver stall pattern, switching to a random mode after each random-length run
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 300);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= 1'($urandom_range(0, 1));
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= (stall_tick % 3 == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic apb_access(input logic write, input logic [2:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input int ptr, input int len);
        apb_access(1'b1, ADDR_POINTER_REG, 32'(ptr));
        apb_access(1'b0, ADDR_POINTER_REG, '0);
        apb_access(1'b1, ADDR_PROGRAM_LEN, 32'(len));
        apb_access(1'b0, ADDR_PROGRAM_LEN, '0);
        bound_reg = ptr;
        jump_span = (len < 1) ? 1 : ((len > 200) ? 200 : len);
    endtask

    task automatic send_instruction(input logic [3:0] op, input logic [31:0] a,
                                    input logic [31:0] b, input logic [2:0] d);
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_operand_a  <= a;
        i_operand_b  <= b;
        i_dest_index <= d;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        item_count++;
    endtask

    function automatic logic [31:0] pick_operand();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 88) return $urandom_range(0, NUM_REGS - 1);
        if (roll < 92) begin
            case ($urandom_range(0, 3))
                0: return 32'(NUM_REGS);
                1: return 32'hffff_ffff;
                2: return 32'h8000_0000;
                default: return 32'h7fff_ffff;
            endcase
        end
        return $urandom();
    endfunction

    // writes to the bound register are mostly redirected; the rest set it to a small immediate or a compare result
    task automatic send_random();
        logic [3:0]  op;
        logic [31:0] a;
        logic [31:0] b;
        logic [2:0]  d;
        int          gap;
        int          roll;
        if (burst_left == 0) begin
            roll = $urandom_range(0, 19);
            if (roll < 6) gap = 0;
            else if (roll < 18) gap = $urandom_range(1, 6);
            else gap = $urandom_range(10, 30);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        op = 4'($urandom_range(0, 15));
        a  = pick_operand();
        b  = pick_operand();
        if ($urandom_range(0, 99) < 6) d = 3'($urandom_range(NUM_REGS, 7));
        else d = 3'($urandom_range(0, NUM_REGS - 1));
        if (bound_reg < NUM_REGS && d == bound_reg) begin
            if ($urandom_range(0, 2) != 0) begin
                d = 3'((int'(d) + 1) % NUM_REGS);
            end else if (op < OP_GTIR) begin
                op = OP_SETI;
                a  = $urandom_range(0, jump_span - 1);
            end
        end
        send_instruction(op, a, b, d);
    endtask

    task automatic wait_drain(input int settle);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values, then steps against an empty program
        apb_access(1'b0, ADDR_POINTER_REG, '0);
        apb_access(1'b0, ADDR_PROGRAM_LEN, '0);
        send_instruction(OP_ADDI, 32'd1, 32'd5, 3'd1);
        send_instruction(OP_SETI, 32'd7, 32'd0, 3'd2);
        wait_drain(4);

        set_config(0, 4096);
        send_instruction(OP_ADDI, 32'd1, 32'h7fff_ffff, 3'd1);
        send_instruction(OP_ADDI, 32'd2, 32'h8000_0000, 3'd2);
        send_instruction(OP_MULR, 32'd1, 32'd2, 3'd3);
        send_instruction(OP_MULI, 32'd3, 32'h7fff_ffff, 3'd3);
        send_instruction(OP_MULR, 32'd3, 32'd3, 3'd3);
        send_instruction(OP_BANR, 32'd1, 32'd2, 3'd4);
        send_instruction(OP_BANI, 32'd3, 32'hffff_ffff, 3'd4);
        send_instruction(OP_BORR, 32'd1, 32'd2, 3'd5);
        send_instruction(OP_BORI, 32'd5, 32'h8000_0000, 3'd5);
        send_instruction(OP_SETR, 32'd3, 32'd12345, 3'd1);
        send_instruction(OP_SETI, 32'hffff_ffff, 32'h8000_0000, 3'd2);
        send_instruction(OP_GTIR, 32'd5, 32'd2, 3'd4);
        send_instruction(OP_GTRI, 32'd2, 32'hffff_ffff, 3'd4);
        send_instruction(OP_GTRR, 32'd1, 32'd2, 3'd5);
        send_instruction(OP_EQIR, 32'hffff_ffff, 32'd2, 3'd4);
        send_instruction(OP_EQRI, 32'd2, 32'hffff_ffff, 3'd5);
        send_instruction(OP_EQRR, 32'd3, 32'd3, 3'd4);
        // out-of-range destination and operand indices
        send_instruction(OP_ADDR, 32'd1, 32'd2, 3'd6);
        send_instruction(OP_BORI, 32'd1, 32'd0, 3'd7);
        send_instruction(OP_ADDR, 32'd6, 32'd1, 3'd1);
        send_instruction(OP_MULR, 32'd1, 32'hffff_ffff, 3'd2);
        send_instruction(OP_GTIR, 32'h8000_0000, 32'h7fff_ffff, 3'd3);
        // writes through the bound register
        send_instruction(OP_SETR, 32'd0, 32'd0, 3'd0);
        send_instruction(OP_ADDI, 32'd0, 32'd5, 3'd0);
        send_instruction(OP_EQRR, 32'd0, 32'd0, 3'd0);
        wait_drain(4);

        for (int p = 0; p < PHASES; p++) begin
            set_config(phase_ptr[p], phase_len[p]);
            burst_left = 0;
            repeat (PHASE_ITEMS) send_random();
            wait_drain(4);
        end

        // pointer driven negative, leaving the machine halted for good
        set_config(0, 4096);
        send_instruction(OP_SETI, 32'h8000_0000, 32'd0, 3'd0);
        repeat (3) send_random();
        wait_drain(10);

        $display("covered %0d instructions under %0d pointer/length settings and %0d config writes",
                 item_count, PHASES + 2, config_writes);
        $display("%0d results checked, %0d halted, %0d with a bad register index",
                 result_count, halted_count, bad_count);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/sixrm_pkg.sv
hw/rtl/sixrm_alu.sv
hw/rtl/six_register_machine_execute_top.sv
bench/six_register_machine_execute_checker.sv
bench/six_register_machine_execute_top_tb.sv
